FILE: design/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared sizes, types and helpers of the multichannel moving average block.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int TAPS     = 16;
    localparam int CHANNELS = 5;
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = SAMPLE_W + $clog2(TAPS);

    typedef logic [CH_W-1:0]     t_channel;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;

    typedef struct packed {
        logic     en;
        t_channel ch;
    } t_shift;

    function automatic logic ch_in_range(input t_channel ch);
        return {1'b0, ch} < (CH_W + 1)'(CHANNELS);
    endfunction

endpackage

FILE: design/mma_in_if.sv
// ----------------------------------------------------------------------------
// mma_in_if
// Sample channel: a channel number and a raw converter sample.
// ----------------------------------------------------------------------------
interface mma_in_if
    import mma_pkg::*;
    ;
    logic     valid;
    logic     ready;
    t_channel channel;
    t_sample  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

FILE: design/mma_out_if.sv
// ----------------------------------------------------------------------------
// mma_out_if
// Result channel: the echoed channel number and the window average.
// ----------------------------------------------------------------------------
interface mma_out_if
    import mma_pkg::*;
    ;
    logic     valid;
    logic     ready;
    t_channel out_channel;
    t_sample  average;

    modport source (output valid, output out_channel, output average, input ready);
    modport sink   (input valid, input out_channel, input average, output ready);
endinterface

FILE: design/mma_tap_cell.sv
// ----------------------------------------------------------------------------
// mma_tap_cell
// One tap position of the window, held for every channel. On a shift the
// selected channel's entry takes the value handed on by the previous cell.
// ----------------------------------------------------------------------------
module mma_tap_cell
    import mma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_shift  i_shift,
    input  t_sample i_tap,
    output t_sample o_tap
);

    t_sample r_entry [CHANNELS];

    assign o_tap = ch_in_range(i_shift.ch) ? r_entry[i_shift.ch] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_entry[c] <= '0;
            end
        end else if (i_shift.en) begin
            r_entry[i_shift.ch] <= i_tap;
        end
    end

endmodule

FILE: design/mma_accum.sv
// ----------------------------------------------------------------------------
// mma_accum
// Running window sums per channel and a two-entry result buffer.
// ----------------------------------------------------------------------------
module mma_accum
    import mma_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_shift   i_shift,
    input  t_sample  i_sample,
    input  t_sample  i_oldest,
    output logic     o_ready,
    mma_out_if.source o_out
);

    t_sum     r_sum [CHANNELS];
    logic     r_out_valid;
    t_channel r_out_ch;
    t_sample  r_out_avg;
    logic     r_skid_valid;
    t_channel r_skid_ch;
    t_sample  r_skid_avg;

    t_sum     n_sum;
    t_sample  n_avg;
    logic     pop;

    always_comb begin
        n_sum = '0;
        n_avg = '0;
        if (i_shift.en) begin
            n_sum = r_sum[i_shift.ch] - t_sum'(i_oldest) + t_sum'(i_sample);
            n_avg = SAMPLE_W'(n_sum / TAPS);
        end
    end

    assign pop     = r_out_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_shift.en) begin
            r_sum[i_shift.ch] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_ch     <= r_skid_ch;
                r_out_avg    <= r_skid_avg;
                r_skid_valid <= 1'b0;
            end
        end else if (i_accept) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
                r_out_ch    <= i_shift.ch;
                r_out_avg   <= n_avg;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_ch    <= i_shift.ch;
                r_skid_avg   <= n_avg;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_ch;
    assign o_out.average     = r_out_avg;

endmodule

FILE: design/multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Boxcar average over the last TAPS samples of each converter channel.
// ----------------------------------------------------------------------------
// Samples enter on i_in, each tagged with its channel. Every accepted item
// yields exactly one result on o_out, in order: the channel echoed and the
// window sum divided by TAPS, truncated. An item with a channel outside the
// supported range leaves all windows untouched and returns an average of 0.
// The window is a row of TAPS cells, each holding one tap for every channel;
// an accepted sample shifts its channel's entries one cell along, while a
// per-channel running sum adds the new sample and drops the oldest.
// One item is accepted per cycle while i_in.ready is high. Each result is
// registered in a two-entry result buffer, which keeps the input open while
// one result waits; i_in.ready falls only when both entries are full, and
// results are held unchanged while the receiver stalls.
// Reset clears all windows and sums to zero and empties the result buffer,
// so early results of a channel average its samples together with zeros.
// ----------------------------------------------------------------------------
module multichannel_moving_average
    import mma_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mma_in_if.sink    i_in,
    mma_out_if.source o_out
);

    logic    accept;
    logic    ready;
    t_shift  shift;
    t_sample tap [TAPS+1];

    assign accept   = i_in.valid && ready;
    assign i_in.ready = ready;
    assign shift.ch = i_in.channel;
    assign shift.en = accept && ch_in_range(i_in.channel);
    assign tap[0]   = i_in.sample;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        mma_tap_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_tap   (tap[k]),
            .o_tap   (tap[k+1])
        );
    end

    mma_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_shift  (shift),
        .i_sample (i_in.sample),
        .i_oldest (tap[TAPS]),
        .o_ready  (ready),
        .o_out    (o_out)
    );

endmodule

FILE: design/mma_checker.sv
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks of the multichannel moving average block.
// ----------------------------------------------------------------------------
module mma_checker
    import mma_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     i_in_ready,
    input t_channel i_in_channel,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_channel i_out_channel,
    input t_sample  i_out_average
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_out_valid |=> i_out_valid && i_out_channel == $past(i_in_channel))
        else $error("result does not follow item into empty buffer");

    a_bad_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_out_valid && !ch_in_range(i_in_channel) |=> i_out_average == '0)
        else $error("out-of-range channel gave nonzero average");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_channel  (i_in.channel),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_channel (o_out.out_channel),
    .i_out_average (o_out.average)
);
